// ----- hdl/utf8_sd_pkg.sv -----
// Shared types, constants and functions for the UTF-8 stream decoder.
// Used by the channel interfaces and by every module of the decoder.
`timescale 1ns / 1ps

package utf8_sd_pkg;

    localparam int BYTE_W        = 8;
    localparam int CP_W          = 21;
    localparam int STATUS_W      = 2;
    localparam int STATE_W       = 4;
    localparam int CLASS_W       = 4;
    localparam int NUM_CLASSES   = 12;
    localparam int NUM_STATES    = 9;
    localparam int IDX_W         = 7;
    localparam int QUEUE_DEPTH   = 2;

    localparam logic [STATE_W-1:0] ST_ACCEPT = 4'd0;
    localparam logic [STATE_W-1:0] ST_REJECT = 4'd1;
    localparam logic [STATE_W-1:0] ST_LAST   = 4'(NUM_STATES - 1);

    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_REJECTED  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_TRUNCATED = 2'd2;

    localparam logic [CLASS_W-1:0] CL_ASCII   = 4'd0;
    localparam logic [CLASS_W-1:0] CL_CONT_LO = 4'd1;
    localparam logic [CLASS_W-1:0] CL_LEAD2   = 4'd2;
    localparam logic [CLASS_W-1:0] CL_LEAD3   = 4'd3;
    localparam logic [CLASS_W-1:0] CL_ED      = 4'd4;
    localparam logic [CLASS_W-1:0] CL_F4      = 4'd5;
    localparam logic [CLASS_W-1:0] CL_LEAD4   = 4'd6;
    localparam logic [CLASS_W-1:0] CL_CONT_HI = 4'd7;
    localparam logic [CLASS_W-1:0] CL_INVALID = 4'd8;
    localparam logic [CLASS_W-1:0] CL_CONT_MD = 4'd9;
    localparam logic [CLASS_W-1:0] CL_E0      = 4'd10;
    localparam logic [CLASS_W-1:0] CL_F0      = 4'd11;

    // Transition table, indexed by state times the class count plus class.
    localparam logic [STATE_W-1:0] NEXT_STATE [NUM_STATES*NUM_CLASSES] = '{
        4'd0, 4'd1, 4'd2, 4'd3, 4'd5, 4'd8, 4'd7, 4'd1, 4'd1, 4'd1, 4'd4, 4'd6,
        4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1,
        4'd1, 4'd0, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd0, 4'd1, 4'd0, 4'd1, 4'd1,
        4'd1, 4'd2, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd2, 4'd1, 4'd2, 4'd1, 4'd1,
        4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd2, 4'd1, 4'd1, 4'd1, 4'd1,
        4'd1, 4'd2, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd2, 4'd1, 4'd1,
        4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd3, 4'd1, 4'd3, 4'd1, 4'd1,
        4'd1, 4'd3, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd3, 4'd1, 4'd3, 4'd1, 4'd1,
        4'd1, 4'd3, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1
    };

    typedef struct packed {
        logic [BYTE_W-1:0]  byte_in;
        logic               is_last;
        logic [CLASS_W-1:0] cls;
    } entry_t;

    function automatic logic [CLASS_W-1:0] byte_class(input logic [BYTE_W-1:0] b);
        logic [CLASS_W-1:0] c;
        priority if (b < 8'h80) c = CL_ASCII;
        else if (b < 8'h90)     c = CL_CONT_LO;
        else if (b < 8'hA0)     c = CL_CONT_MD;
        else if (b < 8'hC0)     c = CL_CONT_HI;
        else if (b < 8'hC2)     c = CL_INVALID;
        else if (b < 8'hE0)     c = CL_LEAD2;
        else if (b == 8'hE0)    c = CL_E0;
        else if (b == 8'hED)    c = CL_ED;
        else if (b < 8'hF0)     c = CL_LEAD3;
        else if (b == 8'hF0)    c = CL_F0;
        else if (b < 8'hF4)     c = CL_LEAD4;
        else if (b == 8'hF4)    c = CL_F4;
        else                    c = CL_INVALID;
        return c;
    endfunction

endpackage

// ----- hdl/utf8_sd_if.sv -----
// Channel interfaces of the UTF-8 stream decoder: the byte channel and the result channel.
// Depends on utf8_sd_pkg for the field widths.
`timescale 1ns / 1ps

interface utf8_sd_byte_if;
    logic                             valid;
    logic                             ready;
    logic [utf8_sd_pkg::BYTE_W-1:0]   byte_in;
    logic                             is_last;

    modport source (output valid, output byte_in, output is_last, input ready);
    modport sink   (input valid, input byte_in, input is_last, output ready);
endinterface

interface utf8_sd_result_if;
    logic                             valid;
    logic                             ready;
    logic [utf8_sd_pkg::CP_W-1:0]     code_point;
    logic                             has_code_point;
    logic                             error_now;
    logic                             end_of_string;
    logic [utf8_sd_pkg::STATUS_W-1:0] string_status;

    modport source (output valid, output code_point, output has_code_point,
                    output error_now, output end_of_string, output string_status,
                    input ready);
    modport sink   (input valid, input code_point, input has_code_point,
                    input error_now, input end_of_string, input string_status,
                    output ready);
endinterface

// ----- hdl/utf8_sd_front.sv -----
// Front end of the decoder: takes byte beats and tags each with its character class.
// Depends on utf8_sd_pkg and the byte channel interface.
`timescale 1ns / 1ps

module utf8_sd_front (
    utf8_sd_byte_if.sink         byte_stream,
    output utf8_sd_pkg::entry_t  push_entry,
    output logic                 push_valid,
    input  logic                 push_ready
);
    import utf8_sd_pkg::*;

    assign byte_stream.ready  = push_ready;
    assign push_valid         = byte_stream.valid;
    assign push_entry.byte_in = byte_stream.byte_in;
    assign push_entry.is_last = byte_stream.is_last;
    assign push_entry.cls     = byte_class(byte_stream.byte_in);

endmodule

// ----- hdl/utf8_sd_queue.sv -----
// Short queue of classified bytes between the front and back ends.
// Depends on utf8_sd_pkg for the entry type.
`timescale 1ns / 1ps

module utf8_sd_queue #(
    parameter int DEPTH = utf8_sd_pkg::QUEUE_DEPTH
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  utf8_sd_pkg::entry_t  push_entry,
    input  logic                 push_valid,
    output logic                 push_ready,
    output utf8_sd_pkg::entry_t  pop_entry,
    output logic                 pop_valid,
    input  logic                 pop_ready
);
    import utf8_sd_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    entry_t             slots [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               do_push, do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_entry  = slots[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// ----- hdl/utf8_sd_back.sv -----
// Back end of the decoder: steps the validating automaton, builds code points and
// holds the result register. Depends on utf8_sd_pkg and the result channel interface.
`timescale 1ns / 1ps

module utf8_sd_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  utf8_sd_pkg::entry_t  pop_entry,
    input  logic                 pop_valid,
    output logic                 pop_ready,
    utf8_sd_result_if.source     result_stream
);
    import utf8_sd_pkg::*;

    logic [STATE_W-1:0]  state_reg, state_next;
    logic [CP_W-1:0]     acc_reg, acc_next;
    logic                out_valid_reg, out_valid_next;
    logic [CP_W-1:0]     code_point_reg;
    logic                has_cp_reg;
    logic                error_now_reg;
    logic                eos_reg;
    logic [STATUS_W-1:0] status_reg;

    logic [STATE_W-1:0]  prev;
    logic [IDX_W-1:0]    idx;
    logic [STATE_W-1:0]  next;
    logic [BYTE_W-1:0]   lead_bits;
    logic [CP_W-1:0]     acc;
    logic                has_cp, err_now, emit, do_pop;
    logic [STATUS_W-1:0] status;

    assign pop_ready = !out_valid_reg || result_stream.ready;
    assign do_pop    = pop_valid && pop_ready;

    always_comb
    begin
        prev      = (state_reg > ST_LAST) ? ST_REJECT : state_reg;
        idx       = IDX_W'(prev) * IDX_W'(NUM_CLASSES) + IDX_W'(pop_entry.cls);
        next      = NEXT_STATE[idx];
        lead_bits = (8'hFF >> pop_entry.cls) & pop_entry.byte_in;
        if (prev == ST_ACCEPT)
        begin
            acc = CP_W'(lead_bits);
        end
        else
        begin
            acc = {acc_reg[CP_W-7:0], pop_entry.byte_in[5:0]};
        end
        if (next == ST_REJECT)
        begin
            acc = '0;
        end
        has_cp  = (next == ST_ACCEPT);
        err_now = (next == ST_REJECT) && (prev != ST_REJECT);
        status  = STATUS_OK;
        if (pop_entry.is_last)
        begin
            if (next == ST_REJECT)
            begin
                status = STATUS_REJECTED;
            end
            else if (next != ST_ACCEPT)
            begin
                status = STATUS_TRUNCATED;
            end
        end
        emit = has_cp || err_now || pop_entry.is_last;

        state_next     = state_reg;
        acc_next       = acc_reg;
        out_valid_next = out_valid_reg && !result_stream.ready;
        if (do_pop)
        begin
            state_next = pop_entry.is_last ? ST_ACCEPT : next;
            acc_next   = pop_entry.is_last ? '0 : acc;
            if (emit)
            begin
                out_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_ACCEPT;
            acc_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            acc_reg       <= acc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_pop && emit)
        begin
            code_point_reg <= has_cp ? acc : '0;
            has_cp_reg     <= has_cp;
            error_now_reg  <= err_now;
            eos_reg        <= pop_entry.is_last;
            status_reg     <= status;
        end
    end

    assign result_stream.valid          = out_valid_reg;
    assign result_stream.code_point     = code_point_reg;
    assign result_stream.has_code_point = has_cp_reg;
    assign result_stream.error_now      = error_now_reg;
    assign result_stream.end_of_string  = eos_reg;
    assign result_stream.string_status  = status_reg;

endmodule

// ----- hdl/utf8_stream_decoder.sv -----
// Validating UTF-8 stream decoder. The decoder takes one byte beat per clock cycle
// and sustains that rate while the result side keeps up; a result passes from its byte
// through the class queue and then the result register. The rate is set by the
// automaton step in the back end, which reads the state it wrote in the previous
// cycle. A result is given for each finished code point, for the byte that makes
// the string invalid, and always for the last byte, which carries the status of the
// whole string. The queue depth is a parameter.
`timescale 1ns / 1ps

module utf8_stream_decoder #(
    parameter int QUEUE_DEPTH = utf8_sd_pkg::QUEUE_DEPTH
) (
    input  logic              clk,
    input  logic              rst_n,
    utf8_sd_byte_if.sink      byte_stream,
    utf8_sd_result_if.source  result_stream
);
    import utf8_sd_pkg::*;

    entry_t push_entry;
    logic   push_valid, push_ready;
    entry_t pop_entry;
    logic   pop_valid, pop_ready;

    utf8_sd_front u_front (
        .byte_stream (byte_stream),
        .push_entry  (push_entry),
        .push_valid  (push_valid),
        .push_ready  (push_ready)
    );

    utf8_sd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_entry (push_entry),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .pop_entry  (pop_entry),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready)
    );

    utf8_sd_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .pop_entry     (pop_entry),
        .pop_valid     (pop_valid),
        .pop_ready     (pop_ready),
        .result_stream (result_stream)
    );

endmodule

// ----- hdl/utf8_sd_checker.sv -----
// Assertions on the result channel of the UTF-8 stream decoder, bound to the top level.
// Depends on utf8_sd_pkg for the field widths and on the result channel of the top level.
`timescale 1ns / 1ps

module utf8_sd_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              valid,
    input logic                              ready,
    input logic [utf8_sd_pkg::CP_W-1:0]      code_point,
    input logic                              has_code_point,
    input logic                              error_now,
    input logic                              end_of_string,
    input logic [utf8_sd_pkg::STATUS_W-1:0]  string_status
);

    a_stall_hold : assert property (@(posedge clk) disable iff (!rst_n)
        (valid && !ready) |=>
            (valid && $stable(code_point) && $stable(end_of_string)))
        else $error("Stalled result beat changed.");

    a_cp_xor_err : assert property (@(posedge clk) disable iff (!rst_n)
        valid |-> !(has_code_point && error_now))
        else $error("Result beat carries both a code point and an error.");

    a_cp_zero : assert property (@(posedge clk) disable iff (!rst_n)
        (valid && !has_code_point) |-> (code_point == '0))
        else $error("Code point is not zero on a beat without one.");

    a_status_at_end : assert property (@(posedge clk) disable iff (!rst_n)
        (valid && !end_of_string) |-> (string_status == '0))
        else $error("String status set on a beat that is not the last.");

endmodule

bind utf8_stream_decoder utf8_sd_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .valid          (result_stream.valid),
    .ready          (result_stream.ready),
    .code_point     (result_stream.code_point),
    .has_code_point (result_stream.has_code_point),
    .error_now      (result_stream.error_now),
    .end_of_string  (result_stream.end_of_string),
    .string_status  (result_stream.string_status)
);

// ----- tb/utf8_stream_decoder_tb.sv -----
// Self-checking testbench for the UTF-8 stream decoder: directed strings, then random
// well-formed, truncated and corrupted strings, with random gaps on both channels.
// Depends on utf8_sd_pkg, the channel interfaces in utf8_sd_if and the decoder itself.
`timescale 1ns / 1ps

module utf8_stream_decoder_tb;

    import utf8_sd_pkg::*;

    localparam int QUIET_LIMIT = 2000;
    localparam int RANDOM_BEATS = 750;

    localparam logic [STATE_W-1:0] ST_NEED1   = 4'd2;
    localparam logic [STATE_W-1:0] ST_NEED2   = 4'd3;
    localparam logic [STATE_W-1:0] ST_E0_NEXT = 4'd4;
    localparam logic [STATE_W-1:0] ST_ED_NEXT = 4'd5;
    localparam logic [STATE_W-1:0] ST_F0_NEXT = 4'd6;
    localparam logic [STATE_W-1:0] ST_NEED3   = 4'd7;
    localparam logic [STATE_W-1:0] ST_F4_NEXT = 4'd8;

    localparam logic [CP_W-1:0] EDGE_CP [10] = '{
        21'h0, 21'h7F, 21'h80, 21'h7FF, 21'h800,
        21'hD7FF, 21'hE000, 21'hFFFF, 21'h10000, 21'h10FFFF
    };

    typedef struct packed {
        logic [BYTE_W-1:0] value;
        logic              last;
    } text_beat_t;

    typedef struct packed {
        logic [CP_W-1:0]     code_point;
        logic                has_code_point;
        logic                error_now;
        logic                end_of_string;
        logic [STATUS_W-1:0] string_status;
    } decoded_t;

    logic clk;
    logic rst_n;

    utf8_sd_byte_if   byte_ch ();
    utf8_sd_result_if result_ch ();

    utf8_stream_decoder dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .byte_stream   (byte_ch),
        .result_stream (result_ch)
    );

    text_beat_t        pending_beats [$];
    decoded_t          expected_results [$];
    logic [BYTE_W-1:0] text [$];

    logic [STATE_W-1:0] dec_state = ST_ACCEPT;
    logic [CP_W-1:0]    dec_acc = '0;

    int unsigned send_gap;
    int unsigned recv_gap;
    logic        send_calm;
    logic        recv_calm;
    int unsigned quiet_cycles;
    int unsigned fail_count = 0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
    end

    function automatic logic [CLASS_W-1:0] class_of(input logic [BYTE_W-1:0] b);
        if (b <= 8'h7F) return CL_ASCII;
        if (b <= 8'h8F) return CL_CONT_LO;
        if (b <= 8'h9F) return CL_CONT_MD;
        if (b <= 8'hBF) return CL_CONT_HI;
        if (b <= 8'hC1) return CL_INVALID;
        if (b <= 8'hDF) return CL_LEAD2;
        if (b == 8'hE0) return CL_E0;
        if (b == 8'hED) return CL_ED;
        if (b <= 8'hEF) return CL_LEAD3;
        if (b == 8'hF0) return CL_F0;
        if (b <= 8'hF3) return CL_LEAD4;
        if (b == 8'hF4) return CL_F4;
        return CL_INVALID;
    endfunction

    function automatic logic [STATE_W-1:0] advance(input logic [STATE_W-1:0] st,
                                                    input logic [CLASS_W-1:0] cls);
        logic is_lo;
        logic is_md;
        logic is_hi;
        is_lo = (cls == CL_CONT_LO);
        is_md = (cls == CL_CONT_MD);
        is_hi = (cls == CL_CONT_HI);
        case (st)
            ST_ACCEPT:
            begin
                case (cls)
                    CL_ASCII: return ST_ACCEPT;
                    CL_LEAD2: return ST_NEED1;
                    CL_LEAD3: return ST_NEED2;
                    CL_E0:    return ST_E0_NEXT;
                    CL_ED:    return ST_ED_NEXT;
                    CL_F0:    return ST_F0_NEXT;
                    CL_LEAD4: return ST_NEED3;
                    CL_F4:    return ST_F4_NEXT;
                    default:  return ST_REJECT;
                endcase
            end
            ST_NEED1:   return (is_lo || is_md || is_hi) ? ST_ACCEPT : ST_REJECT;
            ST_NEED2:   return (is_lo || is_md || is_hi) ? ST_NEED1 : ST_REJECT;
            ST_E0_NEXT: return is_hi ? ST_NEED1 : ST_REJECT;
            ST_ED_NEXT: return (is_lo || is_md) ? ST_NEED1 : ST_REJECT;
            ST_F0_NEXT: return (is_md || is_hi) ? ST_NEED2 : ST_REJECT;
            ST_NEED3:   return (is_lo || is_md || is_hi) ? ST_NEED2 : ST_REJECT;
            ST_F4_NEXT: return is_lo ? ST_NEED2 : ST_REJECT;
            default:    return ST_REJECT;
        endcase
    endfunction

    task automatic predict_decode(input logic [BYTE_W-1:0] b, input logic last);
        logic [CLASS_W-1:0] cls;
        logic [STATE_W-1:0] prev;
        logic [STATE_W-1:0] nxt;
        logic [31:0]        acc;
        decoded_t           r;
        prev = dec_state;
        cls = class_of(b);
        if (prev == ST_ACCEPT)
            acc = (32'hFF >> cls) & {24'h0, b};
        else
            acc = {5'h0, dec_acc, 6'h0} | {26'h0, b[5:0]};
        acc = acc & 32'h1F_FFFF;
        nxt = advance(prev, cls);
        if (nxt == ST_REJECT)
            acc = '0;
        r.has_code_point = (nxt == ST_ACCEPT);
        r.error_now = (nxt == ST_REJECT) && (prev != ST_REJECT);
        r.end_of_string = last;
        r.code_point = r.has_code_point ? acc[CP_W-1:0] : '0;
        if (!last)
            r.string_status = STATUS_OK;
        else if (nxt == ST_REJECT)
            r.string_status = STATUS_REJECTED;
        else if (nxt != ST_ACCEPT)
            r.string_status = STATUS_TRUNCATED;
        else
            r.string_status = STATUS_OK;
        if (last)
        begin
            dec_state = ST_ACCEPT;
            dec_acc = '0;
        end
        else
        begin
            dec_state = nxt;
            dec_acc = acc[CP_W-1:0];
        end
        if (r.has_code_point || r.error_now || last)
            expected_results.push_back(r);
    endtask

    task automatic compare_field(input string field, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s expected %0h, got %0h", $time, field, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : drive_bytes
        text_beat_t beat;
        if (!rst_n)
        begin
            byte_ch.valid <= 1'b0;
            byte_ch.byte_in <= '0;
            byte_ch.is_last <= 1'b0;
            send_gap <= 0;
            send_calm <= 1'b0;
        end
        else
        begin
            if (byte_ch.valid && byte_ch.ready)
                predict_decode(byte_ch.byte_in, byte_ch.is_last);
            if (!byte_ch.valid || byte_ch.ready)
            begin
                if (send_gap != 0)
                begin
                    byte_ch.valid <= 1'b0;
                    send_gap <= send_gap - 1;
                end
                else if (pending_beats.size() != 0)
                begin
                    beat = pending_beats.pop_front();
                    byte_ch.valid <= 1'b1;
                    byte_ch.byte_in <= beat.value;
                    byte_ch.is_last <= beat.last;
                    send_gap <= send_calm ? 0 : $urandom_range(0, 3);
                    if ($urandom_range(0, 47) == 0)
                        send_calm <= !send_calm;
                end
                else
                begin
                    byte_ch.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin : collect_results
        decoded_t    got;
        decoded_t    want;
        int unsigned stall;
        if (!rst_n)
        begin
            result_ch.ready <= 1'b0;
            recv_gap <= 0;
            recv_calm <= 1'b0;
        end
        else
        begin
            stall = recv_gap;
            if (result_ch.valid && result_ch.ready)
            begin
                got.code_point = result_ch.code_point;
                got.has_code_point = result_ch.has_code_point;
                got.error_now = result_ch.error_now;
                got.end_of_string = result_ch.end_of_string;
                got.string_status = result_ch.string_status;
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, got %p", $time, got);
                    fail_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    compare_field("code_point", 32'(want.code_point), 32'(got.code_point));
                    compare_field("has_code_point", 32'(want.has_code_point),
                                  32'(got.has_code_point));
                    compare_field("error_now", 32'(want.error_now), 32'(got.error_now));
                    compare_field("end_of_string", 32'(want.end_of_string),
                                  32'(got.end_of_string));
                    compare_field("string_status", 32'(want.string_status),
                                  32'(got.string_status));
                end
                stall = recv_calm ? 0 : $urandom_range(0, 3);
                if ($urandom_range(0, 47) == 0)
                    recv_calm <= !recv_calm;
            end
            if (stall != 0)
            begin
                result_ch.ready <= 1'b0;
                recv_gap <= stall - 1;
            end
            else
            begin
                result_ch.ready <= 1'b1;
                recv_gap <= 0;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((byte_ch.valid && byte_ch.ready) || (result_ch.valid && result_ch.ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles == QUIET_LIMIT)
            begin
                $display("%0t: no beat for %0d cycles", $time, QUIET_LIMIT);
                $display("utf8_stream_decoder_tb failed");
                $finish;
            end
        end
        else
        begin
            quiet_cycles <= 0;
        end
    end

    task automatic queue_text();
        text_beat_t beat;
        for (int i = 0; i < text.size(); i++)
        begin
            beat.value = text[i];
            beat.last = (i == text.size() - 1);
            pending_beats.push_back(beat);
        end
        text.delete();
    endtask

    task automatic append_code_point(input logic [CP_W-1:0] cp);
        if (cp < 21'h80)
        begin
            text.push_back(cp[7:0]);
        end
        else if (cp < 21'h800)
        begin
            text.push_back({3'b110, cp[10:6]});
            text.push_back({2'b10, cp[5:0]});
        end
        else if (cp < 21'h10000)
        begin
            text.push_back({4'b1110, cp[15:12]});
            text.push_back({2'b10, cp[11:6]});
            text.push_back({2'b10, cp[5:0]});
        end
        else
        begin
            text.push_back({5'b11110, cp[20:18]});
            text.push_back({2'b10, cp[17:12]});
            text.push_back({2'b10, cp[11:6]});
            text.push_back({2'b10, cp[5:0]});
        end
    endtask

    function automatic logic [CP_W-1:0] pick_code_point(input bit multi_byte);
        logic [CP_W-1:0] cp;
        case (multi_byte ? $urandom_range(4, 9) : $urandom_range(0, 9))
            0, 1, 2, 3: cp = 21'($urandom_range(0, 'h7F));
            4, 5:       cp = 21'($urandom_range('h80, 'h7FF));
            6, 7:
            begin
                cp = 21'($urandom_range('h800, 'hFFFF));
                if (cp >= 21'hD800 && cp <= 21'hDFFF)
                    cp = cp ^ 21'h2000;
            end
            8:          cp = 21'($urandom_range('h10000, 'h10FFFF));
            default:    cp = EDGE_CP[$urandom_range(0, 9)];
        endcase
        return cp;
    endfunction

    initial
    begin : stimulus
        int unsigned target;
        int unsigned kind;
        int unsigned count;
        int unsigned start;
        int unsigned idx;
        logic [CP_W-1:0] cp;

        // The lowest value of each sequence length, ending on the highest scalar value.
        text = '{8'h00, 8'hC2, 8'h80, 8'hE0, 8'hA0, 8'h80,
                 8'hF0, 8'h90, 8'h80, 8'h80, 8'hF4, 8'h8F, 8'hBF, 8'hBF};
        queue_text();
        // A surrogate sequence rejects at its second byte; the bytes after it are ignored until the end.
        text = '{8'hED, 8'hA0, 8'hFF, 8'h7F};
        queue_text();
        // The string ends in the middle of a sequence.
        text = '{8'hE2, 8'h82};
        queue_text();
        // An invalid byte that is also the last one.
        text = '{8'hFF};
        queue_text();
        text = '{8'hEF, 8'hBF, 8'hBF};
        queue_text();

        target = pending_beats.size() + RANDOM_BEATS;
        while (pending_beats.size() < target)
        begin
            kind = $urandom_range(0, 9);
            count = $urandom_range(1, 6);
            if (kind == 8)
            begin
                repeat (count) text.push_back(8'($urandom_range(0, 255)));
            end
            else
            begin
                repeat (count) append_code_point(pick_code_point(1'b0));
                if (kind == 6)
                begin
                    start = text.size();
                    append_code_point(pick_code_point(1'b1));
                    repeat ($urandom_range(1, text.size() - start - 1)) void'(text.pop_back());
                end
                else if (kind == 7)
                begin
                    idx = $urandom_range(0, text.size() - 1);
                    text[idx] = 8'($urandom_range(0, 255));
                end
                else if (kind == 9)
                begin
                    idx = $urandom_range(0, text.size() - 1);
                    case ($urandom_range(0, 2))
                        0:       text.insert(idx, 8'hC0 + 8'($urandom_range(0, 1)));
                        1:       text.insert(idx, 8'hF5 + 8'($urandom_range(0, 10)));
                        default: text.insert(idx, 8'h80 + 8'($urandom_range(0, 63)));
                    endcase
                end
            end
            queue_text();
        end

        do
            @(negedge clk);
        while (pending_beats.size() != 0 || byte_ch.valid || expected_results.size() != 0);
        repeat (8) @(negedge clk);

        if (fail_count == 0)
            $display("utf8_stream_decoder_tb passed");
        else
            $display("utf8_stream_decoder_tb failed");
        $finish;
    end

endmodule

// ----- files.f -----
hdl/utf8_sd_pkg.sv
hdl/utf8_sd_if.sv
hdl/utf8_sd_front.sv
hdl/utf8_sd_queue.sv
hdl/utf8_sd_back.sv
hdl/utf8_stream_decoder.sv
hdl/utf8_sd_checker.sv
tb/utf8_stream_decoder_tb.sv
